// ----- sv/snbb_pkg.sv -----
package snbb_pkg;

	// default sizing of the bank
	localparam int NUM_SETS_DEF   = 32;
	localparam int NUM_STAGES_DEF = 2;
	localparam int MAX_STAGES     = 8;

	// fixed formats of the data path
	localparam int SAMPLE_BITS = 12;
	localparam int COEF_BITS   = 24;
	localparam int COEF_FRAC   = COEF_BITS - 2;
	localparam int FRAC_BITS   = 8;
	localparam int DATA_W      = 32;
	localparam int SEL_W       = 5;
	localparam int TWORD_W     = 4;

	// widths of command fields, sized for the largest bank
	localparam int STAGE_FIELD_W = $clog2(MAX_STAGES);
	localparam int WORD_FIELD_W  = $clog2(5 * MAX_STAGES + 1);

	// item kinds on the input channel
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TABLE  = 1'b1;

	// operand picked for the multiplier
	typedef enum logic [2:0] {
		OP_X,
		OP_X1,
		OP_X2,
		OP_Y1,
		OP_Y2
	} opnd_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic                     wr;
		logic                     bypass;
		logic                     load;
		logic                     clr_hist;
		logic                     issue;
		opnd_t                    kind;
		logic [WORD_FIELD_W-1:0]  word;
		logic [STAGE_FIELD_W-1:0] stage;
		logic                     fin_stage;
		logic                     fin_scale;
	} ctl_t;

endpackage

// ----- sv/snbb_in_if.sv -----
interface snbb_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [4:0]  select;
	logic [11:0] sample;
	logic [4:0]  table_set;
	logic [3:0]  table_word;
	logic signed [23:0] table_value;

	modport source (output valid, cmd, select, sample, table_set, table_word, table_value,
		input ready);
	modport sink (input valid, cmd, select, sample, table_set, table_word, table_value,
		output ready);
endinterface

// ----- sv/snbb_out_if.sv -----
interface snbb_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] dac_value;

	modport source (output valid, dac_value, input ready);
	modport sink (input valid, dac_value, output ready);
endinterface

// ----- sv/snbb_ctrl.sv -----
module snbb_ctrl #(
	parameter int NUM_STAGES = snbb_pkg::NUM_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_cmd,
	input  logic [snbb_pkg::SEL_W-1:0] in_select,
	input  logic                       out_ready,
	output logic                       in_ready,
	output logic                       out_valid,
	output snbb_pkg::ctl_t             ctl
);

	localparam int SW       = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int WW       = $clog2(5 * NUM_STAGES + 1);
	localparam int LAST_STG = NUM_STAGES - 1;
	localparam int WFW      = snbb_pkg::WORD_FIELD_W;
	localparam int SFW      = snbb_pkg::STAGE_FIELD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_FIN_STAGE,
		S_SCALE,
		S_SDRAIN,
		S_FIN_SCALE
	} state_t;

	state_t                     state_q;
	logic [2:0]                 k_q;
	logic                       drain_q;
	logic [SW-1:0]              stage_q;
	logic [WW-1:0]              word_q;
	logic [snbb_pkg::SEL_W-1:0] last_sel_q;
	logic                       out_valid_q;

	logic in_fire;
	logic take_sample;
	logic take_bypass;
	logic take_filter;
	logic take_table;

	// input transfer decode
	assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire     = in_valid && in_ready;
	assign take_table  = in_fire && (in_cmd == snbb_pkg::CMD_TABLE);
	assign take_sample = in_fire && (in_cmd == snbb_pkg::CMD_SAMPLE);
	assign take_bypass = take_sample && (in_select == '0);
	assign take_filter = take_sample && (in_select != '0);
	assign out_valid   = out_valid_q;

	// commands to the datapath, with the operand for the current tap
	always_comb begin
		case (k_q)
			3'd0:    ctl.kind = snbb_pkg::OP_X;
			3'd1:    ctl.kind = snbb_pkg::OP_X1;
			3'd2:    ctl.kind = snbb_pkg::OP_X2;
			3'd3:    ctl.kind = snbb_pkg::OP_Y1;
			3'd4:    ctl.kind = snbb_pkg::OP_Y2;
			default: ctl.kind = snbb_pkg::OP_X;
		endcase
		if (state_q == S_SCALE) begin
			ctl.kind = snbb_pkg::OP_X;
		end
		ctl.wr        = take_table;
		ctl.bypass    = take_bypass;
		ctl.load      = take_filter;
		ctl.clr_hist  = take_filter && (in_select != last_sel_q);
		ctl.issue     = (state_q == S_ISSUE) || (state_q == S_SCALE);
		ctl.word      = WFW'(word_q);
		ctl.stage     = SFW'(stage_q);
		ctl.fin_stage = (state_q == S_FIN_STAGE);
		ctl.fin_scale = (state_q == S_FIN_SCALE);
	end

	// sequencer: five taps per stage, pipeline drain, stage close, then scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			drain_q     <= 1'b0;
			stage_q     <= '0;
			word_q      <= '0;
			last_sel_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register
			if (take_sample) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (take_filter) begin
						last_sel_q <= in_select;
						k_q        <= '0;
						stage_q    <= '0;
						word_q     <= '0;
						state_q    <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					word_q <= word_q + 1'b1;
					if (k_q == 3'd4) begin
						k_q     <= '0;
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_FIN_STAGE;
					end
				end
				S_FIN_STAGE: begin
					if (stage_q == SW'(LAST_STG)) begin
						state_q <= S_SCALE;
					end else begin
						stage_q <= stage_q + 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_SCALE: begin
					drain_q <= 1'b0;
					state_q <= S_SDRAIN;
				end
				S_SDRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_FIN_SCALE;
					end
				end
				S_FIN_SCALE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/snbb_dp.sv -----
module snbb_dp #(
	parameter int NUM_SETS   = snbb_pkg::NUM_SETS_DEF,
	parameter int NUM_STAGES = snbb_pkg::NUM_STAGES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  snbb_pkg::ctl_t                          ctl,
	input  logic [snbb_pkg::SEL_W-1:0]              select,
	input  logic [snbb_pkg::SAMPLE_BITS-1:0]        sample,
	input  logic [snbb_pkg::SEL_W-1:0]              table_set,
	input  logic [snbb_pkg::TWORD_W-1:0]            table_word,
	input  logic signed [snbb_pkg::COEF_BITS-1:0]   table_value,
	output logic [snbb_pkg::SAMPLE_BITS-1:0]        dac_value
);

	localparam int WORDS  = 5 * NUM_STAGES + 1;
	localparam int DEPTH  = NUM_SETS * WORDS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int WW     = $clog2(WORDS);
	localparam int CB     = snbb_pkg::COEF_BITS;
	localparam int DW     = snbb_pkg::DATA_W;
	localparam int PROD_W = CB + DW;
	localparam int ACC_W  = PROD_W + 3;
	localparam int SB     = snbb_pkg::SAMPLE_BITS;
	localparam int FB     = snbb_pkg::FRAC_BITS;

	// coefficient store
	logic signed [CB-1:0] mem [DEPTH];

	logic [AW-1:0]          base_q;
	logic                   oob_q;
	logic signed [DW-1:0]   x_q;
	logic signed [DW-1:0]   x1_q [NUM_STAGES];
	logic signed [DW-1:0]   x2_q [NUM_STAGES];
	logic signed [DW-1:0]   y1_q [NUM_STAGES];
	logic signed [DW-1:0]   y2_q [NUM_STAGES];
	logic signed [DW-1:0]   held_q;
	logic [SB-1:0]          dac_q;

	logic signed [CB-1:0]     rdata_s1;
	logic                     valid_s1;
	snbb_pkg::opnd_t          kind_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic [AW-1:0]          waddr;
	logic                   wr_ok;
	logic [AW-1:0]          raddr;
	logic [SW-1:0]          stg;
	logic [SW-1:0]          stg_s1;
	logic signed [CB-1:0]   coef_s1;
	logic signed [DW-1:0]   opnd;
	logic signed [ACC_W-1:0] acc_sh;
	logic                   acc_fits;
	logic signed [DW-1:0]   acc_sat;
	logic [snbb_pkg::SEL_W-1:0] set_idx;
	logic signed [DW-1:0]   held_sh;
	logic [SB-1:0]          held_dac;

	// table write address and range check
	assign wr_ok = (32'(table_set) < 32'(NUM_SETS)) && (32'(table_word) < 32'(WORDS));
	assign waddr = AW'(32'(table_set) * 32'(WORDS) + 32'(table_word));

	always_ff @(posedge clk) begin
		if (ctl.wr && wr_ok) begin
			mem[waddr] <= table_value;
		end
	end

	// registered coefficient read
	assign raddr = base_q + AW'(ctl.word[WW-1:0]);

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign set_idx = select - 1'b1;
	assign stg     = ctl.stage[SW-1:0];
	assign stg_s1  = stg;
	assign coef_s1 = oob_q ? '0 : rdata_s1;

	// multiplier operand select
	always_comb begin
		case (kind_s1)
			snbb_pkg::OP_X:  opnd = x_q;
			snbb_pkg::OP_X1: opnd = x1_q[stg_s1];
			snbb_pkg::OP_X2: opnd = x2_q[stg_s1];
			snbb_pkg::OP_Y1: opnd = y1_q[stg_s1];
			snbb_pkg::OP_Y2: opnd = y2_q[stg_s1];
			default:         opnd = x_q;
		endcase
	end

	// floor shift of the accumulator and 32-bit saturation
	assign acc_sh   = acc_q >>> snbb_pkg::COEF_FRAC;
	assign acc_fits = (&acc_sh[ACC_W-1:DW-1]) || !(|acc_sh[ACC_W-1:DW-1]);
	always_comb begin
		if (acc_fits) begin
			acc_sat = acc_sh[DW-1:0];
		end else if (acc_sh[ACC_W-1]) begin
			acc_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(DW-1){1'b1}}};
		end
	end

	// held value to dac code, clamped to the converter range
	assign held_sh = held_q >>> FB;
	always_comb begin
		if (held_sh[DW-1]) begin
			held_dac = '0;
		end else if (|held_sh[DW-2:SB]) begin
			held_dac = '1;
		end else begin
			held_dac = held_sh[SB-1:0];
		end
	end

	// multiply and accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
			if (ctl.load || ctl.fin_stage || ctl.fin_scale) begin
				acc_q <= '0;
			end else if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			kind_s1 <= ctl.kind;
		end
		if (valid_s1) begin
			prod_s2 <= PROD_W'(coef_s1) * PROD_W'(opnd);
		end
	end

	// per-item setup and result register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= AW'(32'(set_idx) * 32'(WORDS));
			oob_q  <= (32'(set_idx) >= 32'(NUM_SETS));
		end
		if (ctl.bypass) begin
			dac_q <= sample;
		end else if (ctl.load) begin
			dac_q <= held_dac;
		end
	end

	// filter state: stage input, history and held output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			held_q <= '0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else begin
			if (ctl.load) begin
				x_q <= $signed({{(DW-SB-FB){1'b0}}, sample, {FB{1'b0}}});
				if (ctl.clr_hist) begin
					for (int i = 0; i < NUM_STAGES; i++) begin
						x1_q[i] <= '0;
						x2_q[i] <= '0;
						y1_q[i] <= '0;
						y2_q[i] <= '0;
					end
				end
			end
			if (ctl.fin_stage) begin
				x2_q[stg] <= x1_q[stg];
				x1_q[stg] <= x_q;
				y2_q[stg] <= y1_q[stg];
				y1_q[stg] <= acc_sat;
				x_q       <= acc_sat;
			end
			if (ctl.fin_scale) begin
				held_q <= acc_sat;
			end
		end
	end

	assign dac_value = dac_q;

endmodule

// ----- sv/switchable_notch_biquad_bank.sv -----
// filter item: each stage issues five taps, drains and closes; then scale issue, drain, close
// bypass and table writes leave the sequencer idle; results show in the cycle after transfer
// throughput: one shared multiplier, a product per cycle while taps issue, one item at a time
// dac result of a filter item is the value left by the previous filter item
// arst_n clears history, held output, last select and handshake state; coefficients
// are undefined until written
module switchable_notch_biquad_bank #(
	parameter int NUM_SETS   = snbb_pkg::NUM_SETS_DEF,
	parameter int NUM_STAGES = snbb_pkg::NUM_STAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	snbb_in_if.sink    in_ch,
	snbb_out_if.source out_ch
);

	snbb_pkg::ctl_t ctl;

	// sequencer
	snbb_ctrl #(
		.NUM_STAGES(NUM_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_select (in_ch.select),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.ctl       (ctl)
	);

	// coefficient store, multiplier and filter state
	snbb_dp #(
		.NUM_SETS  (NUM_SETS),
		.NUM_STAGES(NUM_STAGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.select     (in_ch.select),
		.sample     (in_ch.sample),
		.table_set  (in_ch.table_set),
		.table_word (in_ch.table_word),
		.table_value(in_ch.table_value),
		.dac_value  (out_ch.dac_value)
	);

`ifndef SYNTHESIS
	// no transfer while the multiplier sequence runs
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> !in_ch.ready)
		else $error("input accepted during filter sequence");

	// a result only appears after a sample transfer
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready && !in_ch.cmd))
		else $error("result without a sample transfer");

	// a table write never produces a result
	a_table_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.cmd) |=> !$rose(out_ch.valid))
		else $error("table write produced a result");

	// stage close and scale close never coincide with a tap read or a load
	a_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fin_stage || ctl.fin_scale) |-> !ctl.issue && !ctl.load)
		else $error("finalize overlaps tap read or load");
`endif

endmodule

// ----- verif/tb_switchable_notch_biquad_bank.sv -----
`timescale 1ns / 1ps

module tb_switchable_notch_biquad_bank;

	localparam int NUM_SETS      = snbb_pkg::NUM_SETS_DEF;
	localparam int NUM_STAGES    = snbb_pkg::NUM_STAGES_DEF;
	localparam int SAMPLE_BITS   = snbb_pkg::SAMPLE_BITS;
	localparam int FRAC_BITS     = snbb_pkg::FRAC_BITS;
	localparam int COEF_FRAC     = snbb_pkg::COEF_FRAC;
	localparam int SEL_W         = snbb_pkg::SEL_W;
	localparam int TWORD_W       = snbb_pkg::TWORD_W;
	localparam int STAGE_WORDS   = 5;
	localparam int WORDS_PER_SET = STAGE_WORDS * NUM_STAGES + 1;
	localparam int SCALE_WORD    = STAGE_WORDS * NUM_STAGES;
	localparam longint DAC_MAX   = (longint'(1) << SAMPLE_BITS) - 1;

	// word offsets inside one biquad stage
	localparam int W_B0 = 0;
	localparam int W_B1 = 1;
	localparam int W_B2 = 2;
	localparam int W_A1 = 3;
	localparam int W_A2 = 4;
	localparam int WORD_TOP = (1 << TWORD_W) - 1;

	localparam logic [SEL_W-1:0] SEL_BYPASS = '0;
	// highest set that a select code can reach
	localparam int LAST_CODED_SET = (1 << SEL_W) - 2;

	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int CALM_LO      = 260;
	localparam int CALM_HI      = 330;
	localparam int SETTLE       = 40;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic              cmd;
		logic [SEL_W-1:0]  select;
		logic [11:0]       sample;
		logic [4:0]        table_set;
		logic [TWORD_W-1:0] table_word;
		logic [23:0]       table_value;
		int unsigned       gap;
		bit                drain;
	} bank_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	snbb_in_if  in_bus ();
	snbb_out_if dac_bus ();

	switchable_notch_biquad_bank #(
		.NUM_SETS   (NUM_SETS),
		.NUM_STAGES (NUM_STAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (dac_bus)
	);

	always #6 clk = ~clk;

	// stimulus and expectations
	bank_item_t       pending[$];
	bank_item_t       cur_item;
	logic [11:0]      dac_expected[$];
	int unsigned      stim_count;
	bit               calm_run;
	bit               drain_next;
	int unsigned      usable[$];
	bit               is_usable[NUM_SETS];

	// predictor state
	int               coef_mem[NUM_SETS * WORDS_PER_SET];
	int               stage_hist[4 * NUM_STAGES];
	int               held_y;
	logic [SEL_W-1:0] last_code;

	// handshake bookkeeping
	bit               in_busy;
	bit               in_taken;
	int unsigned      in_idle;
	bit               out_taken;
	int unsigned      out_hold;
	int unsigned      dac_seen;
	int unsigned      mismatches;
	int unsigned      cycle_count;

	function automatic int sat32(longint v);
		if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
		if (v < -longint'(32'sh7FFFFFFF) - 1) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint coef_at(int unsigned set, int unsigned word);
		if (set >= NUM_SETS || word >= WORDS_PER_SET) return 0;
		return longint'(coef_mem[set * WORDS_PER_SET + word]);
	endfunction

	// one input item through the filter bank; table writes give no dac value
	task automatic bank_step(input bank_item_t it, output bit has_dac, output logic [11:0] dac);
		int unsigned set;
		longint acc;
		longint v;
		int x;
		int y;
		int h;
		has_dac = 1'b0;
		dac = '0;
		if (it.cmd == snbb_pkg::CMD_TABLE) begin
			if (it.table_set < NUM_SETS && it.table_word < WORDS_PER_SET)
				coef_mem[it.table_set * WORDS_PER_SET + it.table_word] =
					{{8{it.table_value[23]}}, it.table_value};
		end else if (it.select == SEL_BYPASS) begin
			has_dac = 1'b1;
			dac = it.sample;
		end else begin
			has_dac = 1'b1;
			// a new filtering code starts from clean history
			if (it.select != last_code) begin
				foreach (stage_hist[i]) stage_hist[i] = 0;
				last_code = it.select;
			end
			// dac shows the value left by the previous filter step
			v = longint'(held_y) >>> FRAC_BITS;
			if (v < 0) v = 0;
			if (v > DAC_MAX) v = DAC_MAX;
			dac = v[11:0];
			set = it.select - 1;
			x = int'(it.sample) <<< FRAC_BITS;
			for (int s = 0; s < NUM_STAGES; s++) begin
				h = 4 * s;
				acc = coef_at(set, STAGE_WORDS * s + W_B0) * longint'(x)
					+ coef_at(set, STAGE_WORDS * s + W_B1) * longint'(stage_hist[h])
					+ coef_at(set, STAGE_WORDS * s + W_B2) * longint'(stage_hist[h + 1])
					+ coef_at(set, STAGE_WORDS * s + W_A1) * longint'(stage_hist[h + 2])
					+ coef_at(set, STAGE_WORDS * s + W_A2) * longint'(stage_hist[h + 3]);
				y = sat32(acc >>> COEF_FRAC);
				stage_hist[h + 1] = stage_hist[h];
				stage_hist[h] = x;
				stage_hist[h + 3] = stage_hist[h + 2];
				stage_hist[h + 2] = y;
				x = y;
			end
			held_y = sat32((coef_at(set, SCALE_WORD) * longint'(x)) >>> COEF_FRAC);
		end
	endtask

	// stimulus builders
	task automatic push_item(bank_item_t it);
		it.gap = calm_run ? 0 : $urandom_range(0, 4);
		it.drain = drain_next;
		drain_next = 1'b0;
		pending.push_back(it);
	endtask

	task automatic push_write(int unsigned set, int unsigned word, logic [23:0] value);
		bank_item_t it;
		it.cmd = snbb_pkg::CMD_TABLE;
		it.select = SEL_W'($urandom);
		it.sample = 12'($urandom);
		it.table_set = 5'(set);
		it.table_word = TWORD_W'(word);
		it.table_value = value;
		push_item(it);
		if (word < WORDS_PER_SET)
			stim_count++;
	endtask

	task automatic push_filter(int unsigned set, logic [11:0] smp);
		bank_item_t it;
		it.cmd = snbb_pkg::CMD_SAMPLE;
		it.select = SEL_W'(set + 1);
		it.sample = smp;
		it.table_set = 5'($urandom);
		it.table_word = TWORD_W'($urandom);
		it.table_value = 24'($urandom);
		push_item(it);
		stim_count++;
	endtask

	task automatic push_bypass(logic [11:0] smp);
		bank_item_t it;
		it.cmd = snbb_pkg::CMD_SAMPLE;
		it.select = SEL_BYPASS;
		it.sample = smp;
		it.table_set = 5'($urandom);
		it.table_word = TWORD_W'($urandom);
		it.table_value = 24'($urandom);
		push_item(it);
		stim_count++;
	endtask

	function automatic logic [11:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	// wild values drive saturation, tame ones keep the cascade near unity gain
	function automatic logic [23:0] coef_value(bit wild, int unsigned word);
		int v;
		if (wild) return 24'($urandom);
		v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
		// b0 of each stage and the scale word sit on the same offset
		if (word % STAGE_WORDS == W_B0) v += 1 << 22;
		return v[23:0];
	endfunction

	task automatic push_noise();
		if ($urandom_range(0, 1) == 0)
			push_bypass(rand_sample());
		else
			push_write($urandom_range(0, NUM_SETS - 1),
				$urandom_range(WORDS_PER_SET, WORD_TOP), 24'($urandom));
	endtask

	// writes upto words of a set, taken in shuffled order
	task automatic load_set(int unsigned set, bit wild, int unsigned upto);
		int unsigned order[WORDS_PER_SET];
		int unsigned j;
		int unsigned t;
		foreach (order[i]) order[i] = i;
		for (int i = WORDS_PER_SET - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < upto; i++) begin
			if ($urandom_range(0, 5) == 0)
				push_noise();
			push_write(set, order[i], coef_value(wild, order[i]));
		end
	endtask

	task automatic mark_usable(int unsigned set);
		if (set <= LAST_CODED_SET && !is_usable[set]) begin
			is_usable[set] = 1'b1;
			usable.push_back(set);
		end
	endtask

	// samples on one set, with bypasses, code switches and coefficient updates
	task automatic burst(int unsigned set, int unsigned len);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: push_bypass(rand_sample());
				1: push_filter(usable[$urandom_range(0, usable.size() - 1)], rand_sample());
				2: push_write(set, $urandom_range(0, WORDS_PER_SET - 1),
					coef_value($urandom_range(0, 3) == 0, $urandom_range(0, WORDS_PER_SET - 1)));
				default: push_filter(set, rand_sample());
			endcase
		end
	endtask

	// input transfer and output check at the rising edge
	always @(posedge clk) begin
		bit has_dac;
		logic [11:0] dac;
		logic [11:0] want;
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				bank_step(cur_item, has_dac, dac);
				if (has_dac)
					dac_expected.push_back(dac);
				in_taken = 1'b1;
			end
			if (dac_bus.valid && dac_bus.ready) begin
				if (dac_expected.size() == 0) begin
					$error("dac_value: expected none, actual %0d", dac_bus.dac_value);
					mismatches++;
				end else begin
					want = dac_expected.pop_front();
					if (dac_bus.dac_value !== want) begin
						$error("dac_value: expected %0d, actual %0d", want, dac_bus.dac_value);
						mismatches++;
					end
				end
				dac_seen++;
				out_taken = 1'b1;
			end
		end
	end

	// driver: offers the next pending item after its gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_busy = 1'b0;
				in_idle = 0;
			end
			if (!in_busy && pending.size() > 0) begin
				if (in_idle < pending[0].gap) begin
					in_idle++;
				end else if (!pending[0].drain || dac_expected.size() == 0) begin
					cur_item = pending.pop_front();
					in_busy = 1'b1;
					in_bus.cmd <= cur_item.cmd;
					in_bus.select <= cur_item.select;
					in_bus.sample <= cur_item.sample;
					in_bus.table_set <= cur_item.table_set;
					in_bus.table_word <= cur_item.table_word;
					in_bus.table_value <= cur_item.table_value;
				end
			end
			in_bus.valid <= in_busy;
		end
	end

	// receiver: random stalls per result, one long hold-off, one calm stretch
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				if (dac_seen == HOLD_AT)
					out_hold = HOLD_CYCLES;
				else if (dac_seen >= CALM_LO && dac_seen < CALM_HI)
					out_hold = 0;
				else
					out_hold = $urandom_range(0, 4);
			end
			if (out_hold > 0) begin
				out_hold--;
				dac_bus.ready <= 1'b0;
			end else begin
				dac_bus.ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("switchable_notch_biquad_bank: mismatch");
			$finish;
		end
	end

	initial begin
		bit first;
		bit mid_drained;
		bit wild;
		int unsigned set;
		int unsigned pick;

		in_bus.valid = 1'b0;
		in_bus.cmd = snbb_pkg::CMD_SAMPLE;
		in_bus.select = '0;
		in_bus.sample = '0;
		in_bus.table_set = '0;
		in_bus.table_word = '0;
		in_bus.table_value = '0;
		dac_bus.ready = 1'b0;
		held_y = 0;
		last_code = '0;
		foreach (stage_hist[i]) stage_hist[i] = 0;
		foreach (coef_mem[i]) coef_mem[i] = 0;

		// directed: set 0 as a saturating differentiator, full-scale gain
		calm_run = 1'b1;
		push_write(0, W_B0, 24'h7FFFFF);
		push_write(0, W_B1, 24'h800000);
		push_write(0, W_B2, 24'h000000);
		push_write(0, W_A1, 24'h000000);
		push_write(0, W_A2, 24'h000000);
		push_write(0, STAGE_WORDS + W_B0, 24'h400000);
		for (int w = W_B1; w <= W_A2; w++)
			push_write(0, STAGE_WORDS + w, 24'h000000);
		push_write(0, SCALE_WORD, 24'h7FFFFF);
		mark_usable(0);
		// writes past the last word of a set are dropped
		push_write(0, SCALE_WORD + 3, 24'h123456);
		push_write(NUM_SETS - 1, WORD_TOP, 24'hFFFFFF);
		push_bypass(12'h000);
		push_bypass(12'hFFF);
		// first filter step shows the reset held value
		push_filter(0, 12'hFFF);
		// large held value clips to the maximum
		push_filter(0, 12'h000);
		// negative held value clips to zero
		push_filter(0, 12'hFFF);
		// bypass between filter steps keeps history and code
		push_bypass(12'h800);
		push_filter(0, 12'h4D2);

		// random: whole sets loaded then bursts, partial loads, plain bursts
		stim_count = 0;
		first = 1'b1;
		mid_drained = 1'b0;
		drain_next = 1'b1;
		while (stim_count < RANDOM_ITEMS) begin
			calm_run = ($urandom_range(0, 4) == 0);
			if (!mid_drained && stim_count >= RANDOM_ITEMS / 2) begin
				drain_next = 1'b1;
				mid_drained = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (first || pick < 3) begin
				set = first ? LAST_CODED_SET : $urandom_range(0, NUM_SETS - 1);
				wild = ($urandom_range(0, 2) == 0);
				load_set(set, wild, WORDS_PER_SET);
				mark_usable(set);
				if (set <= LAST_CODED_SET)
					burst(set, $urandom_range(4, 16));
			end else if (pick == 3) begin
				// broken load: only part of a set
				load_set($urandom_range(0, NUM_SETS - 1), 1'b1, $urandom_range(1, WORDS_PER_SET - 1));
			end else begin
				burst(usable[$urandom_range(0, usable.size() - 1)], $urandom_range(4, 24));
			end
			first = 1'b0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || in_busy)
			@(posedge clk);
		while (dac_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("switchable_notch_biquad_bank: match");
		else
			$display("switchable_notch_biquad_bank: mismatch");
		$finish;
	end

endmodule

// ----- switchable_notch_biquad_bank.f -----
sv/snbb_pkg.sv
sv/snbb_in_if.sv
sv/snbb_out_if.sv
sv/snbb_ctrl.sv
sv/snbb_dp.sv
sv/switchable_notch_biquad_bank.sv
verif/tb_switchable_notch_biquad_bank.sv
